// ----- design/fpb_pkg.sv -----
package fpb_pkg;

   // Image limits and address width.
   localparam int MAX_DIMENSION = 4096;
   localparam int ADDR_W        = 32;
   localparam int CNT_W         = $clog2(MAX_DIMENSION);
   localparam int DIM_W         = CNT_W + 1;

   // Register and field widths.
   localparam int DATA_W   = 32;
   localparam int PITCH_W  = 16;
   localparam int OFS_W    = 12;
   localparam int MODE_W   = 2;
   localparam int TOTAL_W  = 27;
   localparam int PROD_W   = DIM_W + PITCH_W;
   localparam int AREA_W   = 2 * DIM_W;
   localparam int XOFF_W   = OFS_W + 1;
   localparam int CSR_IDX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_DEST_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_PITCH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_START      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_START      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_MODE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_BASE  = 3'd7;

   // Pixel depth codes; the spare fourth code is unsupported like the first.
   localparam logic [MODE_W-1:0] DEPTH_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] DEPTH_16    = 2'd1;
   localparam logic [MODE_W-1:0] DEPTH_32    = 2'd2;
   localparam logic [MODE_W-1:0] DEPTH_SPARE = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0]  dest_base;
      logic [PITCH_W-1:0] row_pitch;
      logic [OFS_W-1:0]   x_start;
      logic [OFS_W-1:0]   y_start;
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [MODE_W-1:0]  depth_mode;
      logic [ADDR_W-1:0]  source_base;
   } cfg_type;

   // Register values after reset: both dimensions one, everything else zero.
   localparam cfg_type CFG_RESET = '{
      dest_base:    '0,
      row_pitch:    '0,
      x_start:      '0,
      y_start:      '0,
      image_width:  DIM_W'(1),
      image_height: DIM_W'(1),
      depth_mode:   DEPTH_NONE,
      source_base:  '0
   };

   // Pixel with its position, captured at acceptance.
   typedef struct packed {
      logic [DATA_W-1:0] pixel;
      logic [CNT_W-1:0]  column;
      logic [CNT_W-1:0]  row;
      logic              row_start;
      logic              last;
   } pos_type;

   // Products and packed data, ready for the final address add.
   typedef struct packed {
      logic              write_valid;
      logic              write_half;
      logic [DATA_W-1:0] write_data;
      logic [MODE_W-1:0] depth_mode;
      logic [PROD_W-1:0] row_product;
      logic [XOFF_W-1:0] x_offset;
      logic [AREA_W-1:0] area;
      logic              row_start;
      logic              last;
   } calc_type;

   // A zero dimension counts as one, anything above the limit saturates.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > DIM_W'(MAX_DIMENSION)) begin
         result = DIM_W'(MAX_DIMENSION);
      end
      return result;
   endfunction

   // Keep the top bits of each color channel.
   function automatic logic [15:0] pack_rgb565(input logic [DATA_W-1:0] pixel);
      return {pixel[23:19], pixel[15:10], pixel[7:3]};
   endfunction

endpackage

// ----- design/fpb_if.sv -----
interface fpb_req_if
   import fpb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface fpb_rsp_if
   import fpb_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               write_valid;
   logic [ADDR_W-1:0]  write_address;
   logic [DATA_W-1:0]  write_data;
   logic               write_half;
   logic               last_pixel;
   logic [TOTAL_W-1:0] byte_total;

   modport source (output valid, output write_valid, output write_address,
                   output write_data, output write_half, output last_pixel,
                   output byte_total, input ready);
   modport sink   (input valid, input write_valid, input write_address,
                   input write_data, input write_half, input last_pixel,
                   input byte_total, output ready);
endinterface

// ----- design/fpb_front.sv -----
module fpb_front
   import fpb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   input  logic [DATA_W-1:0] req_pixel,
   output logic              req_ready,
   output logic              pos_valid,
   output pos_type           pos,
   input  logic              pos_ready
);

   logic             pos_valid_ff;
   pos_type          pos_ff;
   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] width_c, height_c;
   logic             row_end, image_end, accept, stage_ready;

   // The input register takes a transaction when it is empty or draining.
   assign stage_ready = !pos_valid_ff || pos_ready;
   assign accept      = req_valid && stage_ready;
   assign req_ready   = stage_ready;

   // Position counters: end of row and end of image against the clamped sizes.
   always_comb begin
      width_c   = clamp_dim(cfg.image_width);
      height_c  = clamp_dim(cfg.image_height);
      row_end   = ({1'b0, column_ff} + DIM_W'(1)) >= width_c;
      image_end = row_end && (({1'b0, row_ff} + DIM_W'(1)) >= height_c);
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (row_end) begin
            column_in = '0;
            row_in    = image_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            column_in = column_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         pos_valid_ff <= 1'b0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         if (stage_ready) begin
            pos_valid_ff <= req_valid;
         end
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff.pixel     <= req_pixel;
         pos_ff.column    <= column_ff;
         pos_ff.row       <= row_ff;
         pos_ff.row_start <= (column_ff == '0);
         pos_ff.last      <= image_end;
      end
   end

   assign pos_valid = pos_valid_ff;
   assign pos       = pos_ff;

endmodule

// ----- design/fpb_calc.sv -----
module fpb_calc
   import fpb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     pos_valid,
   input  pos_type  pos,
   output logic     pos_ready,
   output logic     calc_valid,
   output calc_type calc,
   input  logic     calc_ready
);

   logic             calc_valid_ff;
   calc_type         calc_ff, calc_in;
   logic [DIM_W-1:0] row_index;
   logic             stage_ready;

   assign stage_ready = !calc_valid_ff || calc_ready;
   assign pos_ready   = stage_ready;

   // Pack the pixel, decide the write and form the row and area products.
   always_comb begin
      row_index           = {1'b0, cfg.y_start} + DIM_W'(pos.row);
      calc_in.write_valid = 1'b0;
      calc_in.write_half  = 1'b0;
      calc_in.write_data  = '0;
      if (cfg.depth_mode == DEPTH_16) begin
         calc_in.write_valid = 1'b1;
         calc_in.write_half  = 1'b1;
         calc_in.write_data  = {16'd0, pack_rgb565(pos.pixel)};
      end else if (cfg.depth_mode == DEPTH_32 && cfg.dest_base != cfg.source_base) begin
         calc_in.write_valid = 1'b1;
         calc_in.write_data  = pos.pixel;
      end
      calc_in.depth_mode  = cfg.depth_mode;
      calc_in.row_product = PROD_W'(row_index * cfg.row_pitch);
      calc_in.x_offset    = {1'b0, cfg.x_start} + XOFF_W'(pos.column);
      calc_in.area        = AREA_W'(clamp_dim(cfg.image_width)
                                    * clamp_dim(cfg.image_height));
      calc_in.row_start   = pos.row_start;
      calc_in.last        = pos.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calc_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         calc_valid_ff <= pos_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && pos_valid) begin
         calc_ff <= calc_in;
      end
   end

   assign calc_valid = calc_valid_ff;
   assign calc       = calc_ff;

endmodule

// ----- design/fpb_emit.sv -----
module fpb_emit
   import fpb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ADDR_W-1:0]  dest_base,
   input  logic               calc_valid,
   input  calc_type           calc,
   output logic               calc_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_write_valid,
   output logic [ADDR_W-1:0]  rsp_write_address,
   output logic [DATA_W-1:0]  rsp_write_data,
   output logic               rsp_write_half,
   output logic               rsp_last_pixel,
   output logic [TOTAL_W-1:0] rsp_byte_total
);

   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  row_address_ff, row_base;
   logic [ADDR_W-1:0]  address_in;
   logic [XOFF_W+1:0]  column_bytes;
   logic [TOTAL_W-1:0] total_in;
   logic               write_valid_ff, write_half_ff, last_ff;
   logic [ADDR_W-1:0]  address_ff;
   logic [DATA_W-1:0]  data_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               stage_ready, load;

   assign stage_ready = !rsp_valid_ff || rsp_ready;
   assign calc_ready  = stage_ready;
   assign load        = stage_ready && calc_valid;

   // Row base reloads at column zero; bytes per pixel is a shift.
   always_comb begin
      row_base     = calc.row_start ? dest_base + ADDR_W'(calc.row_product)
                                    : row_address_ff;
      column_bytes = '0;
      total_in     = '0;
      case (calc.depth_mode)
         DEPTH_16: begin
            column_bytes = {1'b0, calc.x_offset, 1'b0};
            total_in     = TOTAL_W'({calc.area, 1'b0});
         end
         DEPTH_32: begin
            column_bytes = {calc.x_offset, 2'b00};
            total_in     = TOTAL_W'({calc.area, 2'b00});
         end
         default: begin
            column_bytes = '0;
            total_in     = '0;
         end
      endcase
      address_in = calc.write_valid ? row_base + ADDR_W'(column_bytes) : '0;
      if (!calc.last) begin
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         row_address_ff <= '0;
      end else begin
         if (stage_ready) begin
            rsp_valid_ff <= calc_valid;
         end
         if (load && calc.row_start) begin
            row_address_ff <= row_base;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         write_valid_ff <= calc.write_valid;
         write_half_ff  <= calc.write_half;
         address_ff     <= address_in;
         data_ff        <= calc.write_data;
         last_ff        <= calc.last;
         total_ff       <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = write_valid_ff;
   assign rsp_write_address = address_ff;
   assign rsp_write_data    = data_ff;
   assign rsp_write_half    = write_half_ff;
   assign rsp_last_pixel    = last_ff;
   assign rsp_byte_total    = total_ff;

endmodule

// ----- design/framebuffer_pitch_blit.sv -----
// Path: an accepted transaction passes the input register, the product stage and
// the result register in that order before its result is shown.
// Throughput: one pixel per cycle; the input register, the product stage and
// the result register each hand on an item every cycle unless the sink stalls.
// Reset (synchronous, active high) empties the pipeline, clears the column and
// row counters and the row base, and returns the registers to their reset values.
module framebuffer_pitch_blit
   import fpb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   fpb_req_if.sink              req_chan,
   fpb_rsp_if.source            rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data
);

   cfg_type  cfg_ff;
   logic     pos_valid, pos_ready, calc_valid, calc_ready;
   pos_type  pos;
   calc_type calc;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DEST_BASE:    cfg_ff.dest_base    <= csr_write_data;
            REG_ROW_PITCH:    cfg_ff.row_pitch    <= csr_write_data[PITCH_W-1:0];
            REG_X_START:      cfg_ff.x_start      <= csr_write_data[OFS_W-1:0];
            REG_Y_START:      cfg_ff.y_start      <= csr_write_data[OFS_W-1:0];
            REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_write_data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_write_data[DIM_W-1:0];
            REG_DEPTH_MODE:   cfg_ff.depth_mode   <= csr_write_data[MODE_W-1:0];
            REG_SOURCE_BASE:  cfg_ff.source_base  <= csr_write_data;
         endcase
      end
   end

   fpb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_chan.valid),
      .req_pixel (req_chan.pixel),
      .req_ready (req_chan.ready),
      .pos_valid (pos_valid),
      .pos       (pos),
      .pos_ready (pos_ready)
   );

   fpb_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pos_valid  (pos_valid),
      .pos        (pos),
      .pos_ready  (pos_ready),
      .calc_valid (calc_valid),
      .calc       (calc),
      .calc_ready (calc_ready)
   );

   fpb_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .dest_base         (cfg_ff.dest_base),
      .calc_valid        (calc_valid),
      .calc              (calc),
      .calc_ready        (calc_ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_write_valid   (rsp_chan.write_valid),
      .rsp_write_address (rsp_chan.write_address),
      .rsp_write_data    (rsp_chan.write_data),
      .rsp_write_half    (rsp_chan.write_half),
      .rsp_last_pixel    (rsp_chan.last_pixel),
      .rsp_byte_total    (rsp_chan.byte_total)
   );

endmodule

// ----- design/fpb_checker.sv -----
module fpb_checker
   import fpb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_write_valid,
   input logic [ADDR_W-1:0]  rsp_write_address,
   input logic [DATA_W-1:0]  rsp_write_data,
   input logic               rsp_last_pixel,
   input logic [TOTAL_W-1:0] rsp_byte_total
);

   logic [2:0] outstanding_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Transactions accepted and not yet delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 3'(req_take) - 3'(rsp_take);
      end
   end

   // A stalled result holds its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_address)
         && $stable(rsp_write_data) && $stable(rsp_byte_total))
      else $error("stalled result changed");

   // Never more in flight than the three pipeline stages hold.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 3'd3)
      else $error("more transactions in flight than pipeline stages");

   // No result without an accepted pixel behind it.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0)
      else $error("result shown with no pixel outstanding");

   // Reset empties the output register.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A byte total is reported only with the last pixel, and a skipped write is empty.
   a_total_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_last_pixel || !rsp_write_valid) |->
         (rsp_last_pixel || rsp_byte_total == '0)
         && (rsp_write_valid || (rsp_write_address == '0 && rsp_write_data == '0)))
      else $error("byte total off the last pixel or payload on a skipped write");

endmodule

bind framebuffer_pitch_blit fpb_checker u_fpb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_write_valid   (rsp_chan.write_valid),
   .rsp_write_address (rsp_chan.write_address),
   .rsp_write_data    (rsp_chan.write_data),
   .rsp_last_pixel    (rsp_chan.last_pixel),
   .rsp_byte_total    (rsp_chan.byte_total)
);
